[src/dapd_pkg.sv]
// ----------------------------------------------------------------------------
// dapd_pkg
// Shared widths, register codes, reset values and the rounding helper of the dual axis
// PID drive.
// ----------------------------------------------------------------------------
`default_nettype none
package dapd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP_LATERAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_LATERAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_LATERAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_TURN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_TURN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_TURN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_CAP    = 3'd7;

	// register widths and reset values
	localparam int GAIN_W = 16;
	localparam int WIN_W  = 8;
	localparam int CAP_W  = 15;

	localparam logic [GAIN_W-1:0] KP_LATERAL_RST = 16'd1475;
	localparam logic [GAIN_W-1:0] KI_LATERAL_RST = 16'd82;
	localparam logic [GAIN_W-1:0] KD_LATERAL_RST = 16'd328;
	localparam logic [GAIN_W-1:0] KP_TURN_RST    = 16'd8192;
	localparam logic [GAIN_W-1:0] KI_TURN_RST    = 16'd33;
	localparam logic [GAIN_W-1:0] KD_TURN_RST    = 16'd3;
	localparam logic [WIN_W-1:0]  WINDOW_RST     = 8'd3;
	localparam logic [CAP_W-1:0]  LAT_CAP_RST    = 15'd3000;

	// item fields
	localparam int TGT_W  = 16;
	localparam int SCL_W  = 9;
	localparam int HEAD_W = 21;
	localparam int ENC_W  = 24;
	localparam int AXP_W  = 7;
	localparam int SIDE_W = 8;

	// fixed factors and limits
	localparam int DIST_FACTOR       = 7660;
	localparam int TURN_INTEGRAL_CAP = 20;
	localparam int POWER_LIMIT       = 60;
	localparam longint LAT_LIMIT     = longint'(POWER_LIMIT) << 24;
	localparam longint TRN_LIMIT     = longint'(POWER_LIMIT) << 16;

	// state and datapath widths
	localparam int ERR_W   = 26;
	localparam int LINT_W  = 16;
	localparam int TERR_W  = 22;
	localparam int TINT_W  = 11;
	localparam int LACC_W  = 30;
	localparam int TACC_W  = 26;
	localparam int SACC_W  = LACC_W + GAIN_W + 1;
	localparam int CNT_W   = $clog2(GAIN_W);
	localparam int MIX_W   = 33;
	localparam int FRAC_W  = 24;

	// divide a q24 value by 2^24, rounding toward zero
	function automatic logic signed [MIX_W-FRAC_W-1:0] trunc_q24(
		input logic signed [MIX_W-1:0] v
	);
		logic signed [MIX_W-FRAC_W-1:0] q;
		q = v[MIX_W-1:FRAC_W];
		if (v[MIX_W-1] && (v[FRAC_W-1:0] != '0)) begin
			q = q + 1'b1;
		end
		return q;
	endfunction

endpackage
`default_nettype wire

[src/dapd_if.sv]
// ----------------------------------------------------------------------------
// dapd_if
// Valid/ready channels of the dual axis PID drive: the sensor item in and the
// drive power item out.
// ----------------------------------------------------------------------------
`default_nettype none
interface dapd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dapd_pkg::TGT_W-1:0]     target_distance;
	logic        [dapd_pkg::SCL_W-1:0]     lateral_scale;
	logic signed [dapd_pkg::HEAD_W-1:0]    target_heading;
	logic signed [dapd_pkg::ENC_W-1:0]     encoder_y;
	logic signed [dapd_pkg::ENC_W-1:0]     encoder_x;
	logic signed [dapd_pkg::HEAD_W-1:0]    heading_now;

	modport source (
		output valid, target_distance, lateral_scale, target_heading,
		       encoder_y, encoder_x, heading_now,
		input  ready
	);
	modport sink (
		input  valid, target_distance, lateral_scale, target_heading,
		       encoder_y, encoder_x, heading_now,
		output ready
	);
endinterface

interface dapd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dapd_pkg::AXP_W-1:0]     lateral_power;
	logic signed [dapd_pkg::AXP_W-1:0]     turn_power;
	logic signed [dapd_pkg::SIDE_W-1:0]    left_power;
	logic signed [dapd_pkg::SIDE_W-1:0]    right_power;

	modport source (
		output valid, lateral_power, turn_power, left_power, right_power,
		input  ready
	);
	modport sink (
		input  valid, lateral_power, turn_power, left_power, right_power,
		output ready
	);
endinterface
`default_nettype wire

[src/dual_axis_pid_drive.sv]
// ----------------------------------------------------------------------------
// dual_axis_pid_drive
// One control tick of a distance PID and a heading PID, mixed into left and
// right drive powers.
//
// Usage:
//   tick  : sensor item in (targets, encoders, heading, lateral scale),
//           valid/ready; ready is high only while the block is idle.
//   power : drive item out (lateral, turn, left, right), valid/ready, held
//           in an output register until taken.
//   cfg   : write-only register port (gains, integral window, lateral cap),
//           written while idle.
// Each item passes, from accept to the next possible accept, through three
// setup steps, the bit-serial gain multipliers (one gain bit per cycle for
// both axes), the bit-serial lateral scale multiplier, one clamp step and
// one output step. The next item is taken while a result waits; when the
// receiver stalls, a finished tick waits in the output step and input stays
// blocked.
// Reset restores the register defaults and clears the PID history.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_axis_pid_drive (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [dapd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dapd_pkg::CFG_DATA_W-1:0]   cfg_data,
	dapd_in_if.sink                                tick,
	dapd_out_if.source                             power
);
	import dapd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_ERR   = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_CLAMP = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	localparam int AVG_W   = ENC_W;
	localparam int DIFF_W  = ENC_W + 1;
	localparam int TP_W    = 30;
	localparam int NUM_W   = 33;
	localparam int LDER_W  = ERR_W + 1;
	localparam int TDER_W  = TERR_W + 1;
	localparam int LSUM_W  = LINT_W + 1;
	localparam int TSUM_W  = TINT_W + 1;
	localparam int LPROD_W = LACC_W + GAIN_W;
	localparam int TPROD_W = TACC_W + GAIN_W;
	localparam int SPROD_W = SACC_W + SCL_W;
	localparam int LATC_W  = 32;
	localparam int TRNC_W  = 24;

	localparam logic signed [SPROD_W-1:0] LAT_HI = SPROD_W'(LAT_LIMIT);
	localparam logic signed [SPROD_W-1:0] LAT_LO = -LAT_HI;
	localparam logic signed [TPROD_W-1:0] TRN_HI = TPROD_W'(TRN_LIMIT);
	localparam logic signed [TPROD_W-1:0] TRN_LO = -TRN_HI;
	localparam logic signed [TSUM_W-1:0]  TCAP_HI = TSUM_W'(TURN_INTEGRAL_CAP);
	localparam logic signed [TSUM_W-1:0]  TCAP_LO = -TCAP_HI;

	// control and configuration
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GAIN_W-1:0] kp_lat_q, ki_lat_q, kd_lat_q;
	logic [GAIN_W-1:0] kp_trn_q, ki_trn_q, kd_trn_q;
	logic [WIN_W-1:0]  win_q;
	logic [CAP_W-1:0]  cap_q;
	logic              out_valid_q;

	// pid history
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [LINT_W-1:0] lint_q;
	logic signed [TERR_W-1:0] last_terr_q;
	logic signed [TINT_W-1:0] tint_q;

	// item datapath
	logic signed [TGT_W-1:0]  tgt_q;
	logic        [SCL_W-1:0]  scl_q;
	logic signed [HEAD_W-1:0] thd_q;
	logic signed [ENC_W-1:0]  ency_q;
	logic signed [ENC_W-1:0]  encx_q;
	logic signed [HEAD_W-1:0] hnow_q;
	logic signed [AVG_W-1:0]  avg_q;
	logic signed [TP_W-1:0]   tprod_q;
	logic signed [TERR_W-1:0] terr_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [TDER_W-1:0] tder_q;
	logic signed [LDER_W-1:0] lder_q;
	logic [GAIN_W-1:0]        gkpl_q, gkil_q, gkdl_q, gkpt_q, gkit_q, gkdt_q;
	logic signed [LACC_W-1:0] lhi_q;
	logic [GAIN_W-1:0]        llo_q;
	logic signed [TACC_W-1:0] thi_q;
	logic [GAIN_W-1:0]        tlo_q;
	logic signed [SACC_W-1:0] shi_q;
	logic [SCL_W-1:0]         slo_q;
	logic signed [LATC_W-1:0] latc_q;
	logic signed [TRNC_W-1:0] trnc_q;
	logic signed [AXP_W-1:0]  lat_pwr_q, trn_pwr_q;
	logic signed [SIDE_W-1:0] left_pwr_q, right_pwr_q;

	// combinational
	logic                      accept;
	logic                      out_free;
	logic signed [DIFF_W-1:0]  enc_diff;
	logic signed [AVG_W-1:0]   avg_d;
	logic signed [NUM_W-1:0]   num;
	logic signed [ERR_W-1:0]   err_d;
	logic [TERR_W-1:0]         terr_abs;
	logic signed [TSUM_W-1:0]  tsum;
	logic signed [TINT_W-1:0]  tint_d;
	logic [ERR_W-1:0]          err_abs;
	logic signed [LSUM_W-1:0]  lsum;
	logic signed [LSUM_W-1:0]  lcap;
	logic signed [LINT_W-1:0]  lint_d;
	logic signed [LACC_W-1:0]  lp_term, ld_term, li_term, lsum_acc;
	logic signed [TACC_W-1:0]  tp_term, td_term, ti_term, tsum_acc;
	logic signed [LPROD_W-1:0] lat_prod;
	logic signed [SACC_W-1:0]  s_term, ssum_acc;
	logic signed [SPROD_W-1:0] lat_full;
	logic signed [TPROD_W-1:0] trn_full;
	logic signed [LATC_W-1:0]  latc_d;
	logic signed [TRNC_W-1:0]  trnc_d;
	logic signed [LATC_W-1:0]  trn_q24;
	logic signed [MIX_W-1:0]   lat_mix, trn_mix, left_mix, right_mix;
	logic signed [MIX_W-FRAC_W-1:0] lat_i, trn_i, left_i, right_i;

	assign accept   = tick.valid && tick.ready;
	assign out_free = !out_valid_q || power.ready;

	assign tick.ready          = (state_q == ST_IDLE);
	assign power.valid         = out_valid_q;
	assign power.lateral_power = lat_pwr_q;
	assign power.turn_power    = trn_pwr_q;
	assign power.left_power    = left_pwr_q;
	assign power.right_power   = right_pwr_q;

	// encoder average and distance error, both truncated toward zero
	always_comb begin
		enc_diff = DIFF_W'(ency_q) - DIFF_W'(encx_q);
		avg_d = AVG_W'(enc_diff >>> 1);
		if (enc_diff[DIFF_W-1] && enc_diff[0]) begin
			avg_d = avg_d + 1'b1;
		end
		num = NUM_W'(tprod_q) - (NUM_W'(avg_q) <<< 8);
		err_d = ERR_W'(num >>> 8);
		if (num[NUM_W-1] && (num[7:0] != '0)) begin
			err_d = err_d + 1'b1;
		end
	end

	// turn integral, windowed and clamped
	always_comb begin
		terr_abs = terr_q[TERR_W-1] ? TERR_W'(-terr_q) : TERR_W'(terr_q);
		tsum = TSUM_W'(tint_q) + TSUM_W'(terr_q);
		if (terr_abs < TERR_W'(win_q)) begin
			if (tsum > TCAP_HI) begin
				tint_d = TINT_W'(TCAP_HI);
			end else if (tsum < TCAP_LO) begin
				tint_d = TINT_W'(TCAP_LO);
			end else begin
				tint_d = TINT_W'(tsum);
			end
		end else begin
			tint_d = '0;
		end
	end

	// lateral integral, windowed and clamped to the cap
	always_comb begin
		err_abs = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
		lsum = LSUM_W'(lint_q) + LSUM_W'(err_q);
		lcap = $signed({2'b00, cap_q});
		if (err_abs < ERR_W'(win_q)) begin
			if (lsum > lcap) begin
				lint_d = LINT_W'(lcap);
			end else if (lsum < -lcap) begin
				lint_d = LINT_W'(-lcap);
			end else begin
				lint_d = LINT_W'(lsum);
			end
		end else begin
			lint_d = '0;
		end
	end

	// serial-parallel multipliers, lsb of each gain first
	always_comb begin
		lp_term  = gkpl_q[0] ? LACC_W'(err_q)  : '0;
		ld_term  = gkdl_q[0] ? LACC_W'(lder_q) : '0;
		li_term  = gkil_q[0] ? LACC_W'(lint_q) : '0;
		lsum_acc = lhi_q + lp_term + ld_term + li_term;
		tp_term  = gkpt_q[0] ? TACC_W'(terr_q) : '0;
		td_term  = gkdt_q[0] ? TACC_W'(tder_q) : '0;
		ti_term  = gkit_q[0] ? TACC_W'(tint_q) : '0;
		tsum_acc = thi_q + tp_term + td_term + ti_term;
		lat_prod = $signed({lhi_q, llo_q});
		s_term   = scl_q[0] ? SACC_W'(lat_prod) : '0;
		ssum_acc = shi_q + s_term;
	end

	// clamp and mix
	always_comb begin
		lat_full = $signed({shi_q, slo_q});
		trn_full = $signed({thi_q, tlo_q});
		if (lat_full > LAT_HI) begin
			latc_d = LATC_W'(LAT_HI);
		end else if (lat_full < LAT_LO) begin
			latc_d = LATC_W'(LAT_LO);
		end else begin
			latc_d = LATC_W'(lat_full);
		end
		if (trn_full > TRN_HI) begin
			trnc_d = TRNC_W'(TRN_HI);
		end else if (trn_full < TRN_LO) begin
			trnc_d = TRNC_W'(TRN_LO);
		end else begin
			trnc_d = TRNC_W'(trn_full);
		end
		trn_q24   = $signed({trnc_q, 8'b0});
		lat_mix   = MIX_W'(latc_q);
		trn_mix   = MIX_W'(trn_q24);
		left_mix  = lat_mix - trn_mix;
		right_mix = lat_mix + trn_mix;
		lat_i     = trunc_q24(lat_mix);
		trn_i     = trunc_q24(trn_mix);
		left_i    = trunc_q24(left_mix);
		right_i   = trunc_q24(right_mix);
	end

	// control, configuration and pid history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			kp_lat_q    <= KP_LATERAL_RST;
			ki_lat_q    <= KI_LATERAL_RST;
			kd_lat_q    <= KD_LATERAL_RST;
			kp_trn_q    <= KP_TURN_RST;
			ki_trn_q    <= KI_TURN_RST;
			kd_trn_q    <= KD_TURN_RST;
			win_q       <= WINDOW_RST;
			cap_q       <= LAT_CAP_RST;
			out_valid_q <= 1'b0;
			last_err_q  <= '0;
			lint_q      <= '0;
			last_terr_q <= '0;
			tint_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_KP_LATERAL: kp_lat_q <= cfg_data[GAIN_W-1:0];
					REG_KI_LATERAL: ki_lat_q <= cfg_data[GAIN_W-1:0];
					REG_KD_LATERAL: kd_lat_q <= cfg_data[GAIN_W-1:0];
					REG_KP_TURN:    kp_trn_q <= cfg_data[GAIN_W-1:0];
					REG_KI_TURN:    ki_trn_q <= cfg_data[GAIN_W-1:0];
					REG_KD_TURN:    kd_trn_q <= cfg_data[GAIN_W-1:0];
					REG_WINDOW:     win_q    <= cfg_data[WIN_W-1:0];
					REG_LAT_CAP:    cap_q    <= cfg_data[CAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (power.valid && power.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					tint_q      <= tint_d;
					last_terr_q <= terr_q;
					state_q     <= ST_PREP;
				end
				ST_PREP: begin
					lint_q     <= lint_d;
					last_err_q <= err_q;
					cnt_q      <= '0;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(GAIN_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCALE: begin
					if (cnt_q == CNT_W'(SCL_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_CLAMP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tgt_q  <= tick.target_distance;
					scl_q  <= tick.lateral_scale;
					thd_q  <= tick.target_heading;
					ency_q <= tick.encoder_y;
					encx_q <= tick.encoder_x;
					hnow_q <= tick.heading_now;
				end
			end
			ST_DIFF: begin
				avg_q   <= avg_d;
				tprod_q <= TP_W'(tgt_q) * TP_W'(DIST_FACTOR);
				terr_q  <= TERR_W'(thd_q) - TERR_W'(hnow_q);
			end
			ST_ERR: begin
				err_q  <= err_d;
				tder_q <= TDER_W'(terr_q) - TDER_W'(last_terr_q);
			end
			ST_PREP: begin
				lder_q <= LDER_W'(err_q) - LDER_W'(last_err_q);
				gkpl_q <= kp_lat_q;
				gkil_q <= ki_lat_q;
				gkdl_q <= kd_lat_q;
				gkpt_q <= kp_trn_q;
				gkit_q <= ki_trn_q;
				gkdt_q <= kd_trn_q;
				lhi_q  <= '0;
				thi_q  <= '0;
			end
			ST_MUL: begin
				lhi_q  <= lsum_acc >>> 1;
				llo_q  <= {lsum_acc[0], llo_q[GAIN_W-1:1]};
				thi_q  <= tsum_acc >>> 1;
				tlo_q  <= {tsum_acc[0], tlo_q[GAIN_W-1:1]};
				gkpl_q <= gkpl_q >> 1;
				gkil_q <= gkil_q >> 1;
				gkdl_q <= gkdl_q >> 1;
				gkpt_q <= gkpt_q >> 1;
				gkit_q <= gkit_q >> 1;
				gkdt_q <= gkdt_q >> 1;
				shi_q  <= '0;
			end
			ST_SCALE: begin
				shi_q <= ssum_acc >>> 1;
				slo_q <= {ssum_acc[0], slo_q[SCL_W-1:1]};
				scl_q <= scl_q >> 1;
			end
			ST_CLAMP: begin
				latc_q <= latc_d;
				trnc_q <= trnc_d;
			end
			ST_OUT: begin
				if (out_free) begin
					lat_pwr_q   <= AXP_W'(lat_i);
					trn_pwr_q   <= AXP_W'(trn_i);
					left_pwr_q  <= SIDE_W'(left_i);
					right_pwr_q <= SIDE_W'(right_i);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[test/dual_axis_pid_drive_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_axis_pid_drive_tb
// Self-checking bench for the dual axis PID drive. Sensor ticks go in over
// valid/ready in random bursts while the power channel stalls on its own
// pattern. A scoreboard keeps a bit-exact copy of both PID loops and of the
// gain registers, predicts the four drive powers of every accepted tick and
// compares them field by field with the power items that come out. The run
// covers directed corner ticks under the defaults and a wide window, then random
// ticks under several register settings: zero window, all-max, all-zero and random gains.
// ----------------------------------------------------------------------------
import dapd_pkg::*;

typedef struct packed {
	logic signed [TGT_W-1:0]  target_distance;
	logic        [SCL_W-1:0]  lateral_scale;
	logic signed [HEAD_W-1:0] target_heading;
	logic signed [ENC_W-1:0]  encoder_y;
	logic signed [ENC_W-1:0]  encoder_x;
	logic signed [HEAD_W-1:0] heading_now;
} tick_item_t;

typedef struct packed {
	logic signed [AXP_W-1:0]  lateral_power;
	logic signed [AXP_W-1:0]  turn_power;
	logic signed [SIDE_W-1:0] left_power;
	logic signed [SIDE_W-1:0] right_power;
} power_item_t;

typedef logic [7:0][CFG_DATA_W-1:0] reg_set_t;

class power_scoreboard;
	localparam longint ONE_Q24 = 64'sd16777216;
	localparam int MAX_REPORTS = 60;

	longint kp_lat, ki_lat, kd_lat, kp_trn, ki_trn, kd_trn, window, lat_cap;
	longint last_err, lat_int, last_terr, trn_int;
	power_item_t expected_power[$];
	int unsigned failures, checked, ticks, integrating, saturated;

	function new();
		kp_lat = longint'(KP_LATERAL_RST);
		ki_lat = longint'(KI_LATERAL_RST);
		kd_lat = longint'(KD_LATERAL_RST);
		kp_trn = longint'(KP_TURN_RST);
		ki_trn = longint'(KI_TURN_RST);
		kd_trn = longint'(KD_TURN_RST);
		window = longint'(WINDOW_RST);
		lat_cap = longint'(LAT_CAP_RST);
		last_err = 0;
		lat_int = 0;
		last_terr = 0;
		trn_int = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_KP_LATERAL: kp_lat = longint'(val);
			REG_KI_LATERAL: ki_lat = longint'(val);
			REG_KD_LATERAL: kd_lat = longint'(val);
			REG_KP_TURN:    kp_trn = longint'(val);
			REG_KI_TURN:    ki_trn = longint'(val);
			REG_KD_TURN:    kd_trn = longint'(val);
			REG_WINDOW:     window = longint'(val[WIN_W-1:0]);
			REG_LAT_CAP:    lat_cap = longint'(val[CAP_W-1:0]);
			default: ;
		endcase
	endfunction

	function longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function void note_tick(tick_item_t t);
		longint tgt, scl, thd, ey, ex, hn, avg, err, deriv, lat, terr, tderiv, trn;
		longint lat_q, trn_q, left_q, right_q;
		power_item_t p;
		tgt = longint'(t.target_distance);
		scl = longint'(t.lateral_scale);
		thd = longint'(t.target_heading);
		ey = longint'(t.encoder_y);
		ex = longint'(t.encoder_x);
		hn = longint'(t.heading_now);

		avg = (ey - ex) / 2;
		err = (tgt * longint'(DIST_FACTOR) - avg * 256) / 256;
		deriv = err - last_err;
		if ((err < 0 ? -err : err) < window) lat_int = lat_int + err;
		else lat_int = 0;
		lat_int = clamp_mag(lat_int, lat_cap);
		lat = err * kp_lat + deriv * kd_lat + lat_int * ki_lat;
		lat = clamp_mag(lat * scl, LAT_LIMIT);

		terr = thd - hn;
		tderiv = terr - last_terr;
		if ((terr < 0 ? -terr : terr) < window) trn_int = trn_int + terr;
		else trn_int = 0;
		trn_int = clamp_mag(trn_int, longint'(TURN_INTEGRAL_CAP));
		trn = terr * kp_trn + tderiv * kd_trn + trn_int * ki_trn;
		trn = clamp_mag(trn, TRN_LIMIT) * 256;

		last_err = err;
		last_terr = terr;

		lat_q = lat / ONE_Q24;
		trn_q = trn / ONE_Q24;
		left_q = (lat - trn) / ONE_Q24;
		right_q = (lat + trn) / ONE_Q24;
		p.lateral_power = lat_q[AXP_W-1:0];
		p.turn_power = trn_q[AXP_W-1:0];
		p.left_power = left_q[SIDE_W-1:0];
		p.right_power = right_q[SIDE_W-1:0];
		expected_power.push_back(p);

		ticks++;
		if (lat_int != 0 || trn_int != 0) integrating++;
		if (lat == LAT_LIMIT || lat == -LAT_LIMIT || trn == (TRN_LIMIT * 256)
				|| trn == -(TRN_LIMIT * 256)) saturated++;
	endfunction

	function void compare_field(string name, logic signed [7:0] want,
			logic signed [7:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function void check_power(power_item_t got);
		power_item_t want;
		if (expected_power.size() == 0) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$error("power item with none expected: lateral %0d turn %0d",
					got.lateral_power, got.turn_power);
			return;
		end
		want = expected_power.pop_front();
		checked++;
		compare_field("lateral_power", SIDE_W'(want.lateral_power),
			SIDE_W'(got.lateral_power));
		compare_field("turn_power", SIDE_W'(want.turn_power), SIDE_W'(got.turn_power));
		compare_field("left_power", want.left_power, got.left_power);
		compare_field("right_power", want.right_power, got.right_power);
	endfunction
endclass

module dual_axis_pid_drive_tb;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 7;
	localparam int PHASE_TICKS = 100;

	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dapd_in_if tick_ch ();
	dapd_out_if power_ch ();

	power_scoreboard sb;

	dual_axis_pid_drive u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.power     (power_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic tick_item_t make_tick(int tgt, int scl, int thd, int ey, int ex,
			int hn);
		tick_item_t t;
		t.target_distance = tgt[TGT_W-1:0];
		t.lateral_scale = scl[SCL_W-1:0];
		t.target_heading = thd[HEAD_W-1:0];
		t.encoder_y = ey[ENC_W-1:0];
		t.encoder_x = ex[ENC_W-1:0];
		t.heading_now = hn[HEAD_W-1:0];
		return t;
	endfunction

	// mostly ticks whose errors sit near the integral window, some wide, some noise
	function automatic tick_item_t rand_tick(int win);
		int pick, spread, tspread, tgt, ex, avg, off, thd, toff;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			return make_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		spread = (pick < 7) ? win + 3 : 3000;
		tspread = (pick < 7) ? win + 3 : 400;
		tgt = int'($urandom_range(0, 40000)) - 20000;
		ex = int'($urandom_range(0, 8000000)) - 4000000;
		off = int'($urandom_range(0, 2 * spread)) - spread;
		avg = (tgt * DIST_FACTOR) / 256 - off;
		thd = int'($urandom_range(0, 2000000)) - 1000000;
		toff = int'($urandom_range(0, 2 * tspread)) - tspread;
		return make_tick(tgt, $urandom_range(0, 511), thd,
			ex + 2 * avg + int'($urandom_range(0, 1)), ex, thd - toff);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 65535));
		return CFG_DATA_W'($urandom_range(0, 4000));
	endfunction

	function automatic reg_set_t pick_settings(int phase_no);
		reg_set_t regs;
		regs[REG_KP_LATERAL] = KP_LATERAL_RST;
		regs[REG_KI_LATERAL] = KI_LATERAL_RST;
		regs[REG_KD_LATERAL] = KD_LATERAL_RST;
		regs[REG_KP_TURN] = KP_TURN_RST;
		regs[REG_KI_TURN] = KI_TURN_RST;
		regs[REG_KD_TURN] = KD_TURN_RST;
		regs[REG_WINDOW] = CFG_DATA_W'(WINDOW_RST);
		regs[REG_LAT_CAP] = CFG_DATA_W'(LAT_CAP_RST);
		case (phase_no)
			0: regs[REG_WINDOW] = '0;
			1: begin
				for (int i = 0; i < 6; i++) regs[i[CFG_IDX_W-1:0]] = 16'hFFFF;
				regs[REG_WINDOW] = 16'd255;
				regs[REG_LAT_CAP] = 16'd32767;
			end
			2: regs = '0;
			3: begin
				for (int i = 0; i < 6; i++) regs[i[CFG_IDX_W-1:0]] = rand_gain();
				regs[REG_WINDOW] = 16'd255;
				regs[REG_LAT_CAP] = '0;
			end
			default: begin
				for (int i = 0; i < 6; i++) regs[i[CFG_IDX_W-1:0]] = rand_gain();
				regs[REG_WINDOW] = CFG_DATA_W'($urandom_range(0, 255));
				regs[REG_LAT_CAP] = ($urandom_range(0, 1) == 0)
					? CFG_DATA_W'($urandom_range(0, 200))
					: CFG_DATA_W'($urandom_range(0, 32767));
			end
		endcase
		return regs;
	endfunction

	task automatic send_tick(tick_item_t t);
		tick_ch.valid <= 1'b1;
		tick_ch.target_distance <= t.target_distance;
		tick_ch.lateral_scale <= t.lateral_scale;
		tick_ch.target_heading <= t.target_heading;
		tick_ch.encoder_y <= t.encoder_y;
		tick_ch.encoder_x <= t.encoder_x;
		tick_ch.heading_now <= t.heading_now;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (sb.expected_power.size() != 0) @(posedge clk);
	endtask

	task automatic write_regs(reg_set_t regs);
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= regs[i[CFG_IDX_W-1:0]];
			@(posedge clk);
			sb.write_reg(i[CFG_IDX_W-1:0], regs[i[CFG_IDX_W-1:0]]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_directed();
		reg_set_t regs;
		send_tick(make_tick(0, 256, 0, 0, 0, 0));
		send_tick(make_tick(0, 256, 0, 2, 0, 0));
		send_tick(make_tick(0, 256, 1, 2, 0, 0));
		send_tick(make_tick(0, 256, 0, 0, 3, 2));
		send_tick(make_tick(1, 0, 0, 0, 0, 0));
		send_tick(make_tick(-1, 511, 0, 0, 0, 0));
		send_tick(make_tick(32767, 511, 1048575, -8388608, 8388607, -1048576));
		send_tick(make_tick(-32768, 511, -1048576, 8388607, -8388608, 1048575));
		send_tick(make_tick(-32768, 256, 0, -8388608, -8388608, 0));
		send_tick(make_tick(100, 300, -5, 5986, 0, -5));
		drain();
		// wide window, tiny lateral cap: both integrals run into their limits
		regs = pick_settings(-1);
		regs[REG_WINDOW] = 16'd255;
		regs[REG_LAT_CAP] = 16'd5;
		write_regs(regs);
		repeat (2) send_tick(make_tick(0, 256, 15, -200, 0, 0));
		repeat (4) send_tick(make_tick(0, 256, -15, 200, 0, 0));
		send_tick(make_tick(0, 256, 255, -510, 0, 0));
		send_tick(make_tick(0, 511, -254, 508, 0, 0));
		send_tick(make_tick(0, 256, 0, 0, 0, 0));
	endtask

	task automatic run_phase(int phase_no, int count);
		int burst_left, gap;
		drain();
		write_regs(pick_settings(phase_no));
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 12);
				if (gap > 0) begin
					tick_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_tick(rand_tick(int'(sb.window)));
			burst_left--;
		end
	endtask

	// output side stalls on its own schedule
	initial begin
		rx_mode_t rx_mode;
		int span, hold;
		forever begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			while (span > 0) begin
				if (rx_mode == RX_BURSTY) begin
					hold = $urandom_range(0, 40);
					if (hold > 0) begin
						power_ch.ready <= 1'b0;
						repeat (hold) @(posedge clk);
					end
					power_ch.ready <= 1'b1;
					@(posedge clk);
					span = span - hold - 1;
				end else begin
					case (rx_mode)
						RX_ALWAYS: power_ch.ready <= 1'b1;
						RX_COIN:   power_ch.ready <= 1'($urandom_range(0, 1));
						default:   power_ch.ready <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
					span--;
				end
			end
		end
	end

	always @(posedge clk) begin
		power_item_t got;
		if (arst_n && power_ch.valid && power_ch.ready) begin
			got.lateral_power = power_ch.lateral_power;
			got.turn_power = power_ch.turn_power;
			got.left_power = power_ch.left_power;
			got.right_power = power_ch.right_power;
			sb.check_power(got);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (power_ch.valid && power_ch.ready)
					|| cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("dual_axis_pid_drive regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_KP_LATERAL;
		cfg_data <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.target_distance <= '0;
		tick_ch.lateral_scale <= '0;
		tick_ch.target_heading <= '0;
		tick_ch.encoder_y <= '0;
		tick_ch.encoder_x <= '0;
		tick_ch.heading_now <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) run_phase(p, PHASE_TICKS);
		drain();
		repeat (40) @(posedge clk);
		$display("%0d ticks predicted and %0d power items compared over %0d register settings",
			sb.ticks, sb.checked, PHASES + 2);
		$display("%0d ticks carried a live integral, %0d drove a power into its limit",
			sb.integrating, sb.saturated);
		if (sb.failures == 0 && sb.expected_power.size() == 0) begin
			$display("dual_axis_pid_drive regression: pass");
		end else begin
			$display("%0d failures, %0d power items never seen", sb.failures,
				sb.expected_power.size());
			$display("dual_axis_pid_drive regression: fail");
		end
		$finish;
	end
endmodule

[filelist.f]
src/dapd_pkg.sv
src/dapd_if.sv
src/dual_axis_pid_drive.sv
test/dual_axis_pid_drive_tb.sv
